// ===== sv/hrlp_pkg.sv =====
// Package for the HEX record line parser: shared types, codes and constants.
// Used by every module of the block; no dependencies of its own.

package hrlp_pkg;

   localparam int unsigned HeaderBytes = 5;
   localparam int unsigned CountW      = 9;
   localparam logic [CountW-1:0] CountMax = '1;
   localparam logic [CountW-1:0] LastOffsetIdx = CountW'(HeaderBytes + 255);

   localparam logic [7:0] ChColon = 8'h3A;

   localparam logic KindData    = 1'b0;
   localparam logic KindSummary = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_FORM = 2'd1,
      STATUS_LENGTH   = 2'd2,
      STATUS_CHECKSUM = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_WAIT = 2'b01,
      PH_BODY = 2'b10
   } phase_type;

   typedef struct packed {
      logic       is_space;
      logic       is_colon;
      logic       is_hex;
      logic [3:0] digit;
   } char_class_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_value;
      logic [7:0]  data_offset;
      logic [7:0]  byte_count;
      logic [15:0] load_address;
      logic [7:0]  record_type;
      logic [7:0]  check_byte;
      status_type  status;
      logic        last;
   } result_type;

endpackage

// ===== sv/hex_record_line_parser_core.sv =====
// HEX record line parser, top level. An item that gives a result passes
// through the input register, then the result register.
// Throughput: one item per cycle while the result side takes items; a stalled
// result holds only items that would produce a further result.
// Reset (synchronous, active high) empties both registers and clears the
// record state to waiting for the colon. Uses hrlp_pkg, hrlp_char_class, hrlp_parse.

module hex_record_line_parser_core
   import hrlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_line_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_value,
   output logic [7:0]  rsp_data_offset,
   output logic [7:0]  rsp_byte_count,
   output logic [15:0] rsp_load_address,
   output logic [7:0]  rsp_record_type,
   output logic [7:0]  rsp_check_byte,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   logic           in_valid_ff;
   logic [7:0]     in_char_ff;
   logic           in_end_ff;
   logic           out_valid_ff, out_valid_in;
   result_type     out_ff;

   char_class_type char_class;
   logic           has_result;
   result_type     result;
   logic           out_free;
   logic           step;

   hrlp_char_class u_class (
      .char_code  (in_char_ff),
      .char_class (char_class)
   );

   hrlp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .line_end   (in_end_ff),
      .char_class (char_class),
      .has_result (has_result),
      .result     (result)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   // advance the held item unless it has a result and the result slot is full and not being taken
   assign step      = in_valid_ff && (!has_result || out_free);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (step && has_result) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_end_ff  <= req_line_end;
      end
      if (step && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_data_value   = out_ff.data_value;
   assign rsp_data_offset  = out_ff.data_offset;
   assign rsp_byte_count   = out_ff.byte_count;
   assign rsp_load_address = out_ff.load_address;
   assign rsp_record_type  = out_ff.record_type;
   assign rsp_check_byte   = out_ff.check_byte;
   assign rsp_status       = out_ff.status;
   assign rsp_last         = out_ff.last;

endmodule

// ===== sv/hrlp_char_class.sv =====
// Character classifier: whitespace, colon and hex digit decode.
// Depends on hrlp_pkg.

module hrlp_char_class
   import hrlp_pkg::*;
(
   input  logic [7:0]     char_code,
   output char_class_type char_class
);

   always_comb begin
      char_class = '0;
      case (char_code) inside
         [8'h09:8'h0D], 8'h20: begin
            char_class.is_space = 1'b1;
         end
         ChColon: begin
            char_class.is_colon = 1'b1;
         end
         [8'h30:8'h39]: begin
            char_class.is_hex = 1'b1;
            char_class.digit  = char_code[3:0];
         end
         [8'h41:8'h46], [8'h61:8'h66]: begin
            char_class.is_hex = 1'b1;
            char_class.digit  = 4'(char_code[2:0] + 3'd1) + 4'd8;
         end
         default: begin
            char_class = '0;
         end
      endcase
   end

endmodule

// ===== sv/hrlp_parse.sv =====
// Record state and per-item decode: header capture, running sum, held-back
// data byte and end-of-line summary. Depends on hrlp_pkg.

module hrlp_parse
   import hrlp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           line_end,
   input  char_class_type char_class,
   output logic           has_result,
   output result_type     result
);

   phase_type         phase_ff, phase_in;
   logic              serr_ff, serr_in;
   logic [3:0]        high_ff, high_in;
   logic              half_ff, half_in;
   logic [CountW-1:0] seen_ff, seen_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        len_ff, len_in;
   logic [15:0]       addr_ff, addr_in;
   logic [7:0]        type_ff, type_in;
   logic [7:0]        pend_ff, pend_in;

   logic              in_body;
   logic [7:0]        byte_val;
   logic [CountW-1:0] data_idx;
   logic              enough;

   always_comb begin
      unique case (phase_ff)
         PH_WAIT: in_body = 1'b0;
         PH_BODY: in_body = 1'b1;
         default: in_body = 1'b0;
      endcase
   end

   assign byte_val = {high_ff, char_class.digit};
   assign data_idx = seen_ff - CountW'(HeaderBytes);
   assign enough   = seen_ff >= CountW'(HeaderBytes);

   always_comb begin
      phase_in = phase_ff;
      serr_in  = serr_ff;
      high_in  = high_ff;
      half_in  = half_ff;
      seen_in  = seen_ff;
      sum_in   = sum_ff;
      len_in   = len_ff;
      addr_in  = addr_ff;
      type_in  = type_ff;
      pend_in  = pend_ff;

      has_result          = 1'b0;
      result              = '0;
      result.byte_count   = len_ff;
      result.load_address = addr_ff;
      result.record_type  = type_ff;

      if (line_end) begin
         has_result        = 1'b1;
         result.kind       = KindSummary;
         result.last       = 1'b1;
         result.check_byte = enough ? pend_ff : 8'h00;
         if (serr_ff || !in_body || !enough || half_ff) begin
            result.status = STATUS_BAD_FORM;
         end else if (data_idx != {1'b0, len_ff}) begin
            result.status = STATUS_LENGTH;
         end else if (sum_ff != 8'h00) begin
            result.status = STATUS_CHECKSUM;
         end else begin
            result.status = STATUS_OK;
         end
         // clear for the next record
         phase_in = PH_WAIT;
         serr_in  = 1'b0;
         high_in  = '0;
         half_in  = 1'b0;
         seen_in  = '0;
         sum_in   = '0;
         len_in   = '0;
         addr_in  = '0;
         type_in  = '0;
         pend_in  = '0;
      end else if (char_class.is_space) begin
         phase_in = phase_ff;
      end else if (char_class.is_colon) begin
         if (in_body) begin
            serr_in = 1'b1;
         end else begin
            phase_in = PH_BODY;
         end
      end else if (!char_class.is_hex || !in_body) begin
         serr_in = 1'b1;
      end else if (!half_ff) begin
         high_in = char_class.digit;
         half_in = 1'b1;
      end else begin
         half_in = 1'b0;
         sum_in  = sum_ff + byte_val;
         case (seen_ff)
            CountW'(0): len_in = byte_val;
            CountW'(1): addr_in = {byte_val, 8'h00};
            CountW'(2): addr_in = {addr_ff[15:8], byte_val};
            CountW'(3): type_in = byte_val;
            default: begin
               // emit the held byte one place late, so the checksum never shows
               if (enough && seen_ff <= LastOffsetIdx) begin
                  has_result         = 1'b1;
                  result.kind        = KindData;
                  result.data_value  = pend_ff;
                  result.data_offset = data_idx[7:0];
               end
               pend_in = byte_val;
            end
         endcase
         if (seen_ff != CountMax) begin
            seen_in = seen_ff + CountW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         serr_ff  <= 1'b0;
         high_ff  <= '0;
         half_ff  <= 1'b0;
         seen_ff  <= '0;
         sum_ff   <= '0;
         len_ff   <= '0;
         addr_ff  <= '0;
         type_ff  <= '0;
         pend_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         serr_ff  <= serr_in;
         high_ff  <= high_in;
         half_ff  <= half_in;
         seen_ff  <= seen_in;
         sum_ff   <= sum_in;
         len_ff   <= len_in;
         addr_ff  <= addr_in;
         type_ff  <= type_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ===== tb/tb_hex_record_line_parser_core.sv =====
// Testbench for hex_record_line_parser_core: directed records, then random HEX record
// lines checked item by item against a local parser model. Depends on hrlp_pkg and the RTL.

module tb_hex_record_line_parser_core;
   timeunit 1ns;
   timeprecision 1ps;
   import hrlp_pkg::*;

   localparam int CycleLimit   = 300000;
   localparam int RandomItems  = 1750;
   localparam int HugeItems    = 1085;
   localparam int PhaseCount   = 5;
   localparam int DataStart    = 5;
   localparam logic [8:0] SeenMax = 9'd511;

   typedef struct {
      logic [7:0] ch;
      logic       eol;
      bit         typed;
      result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_line_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_data_value;
   logic [7:0]  rsp_data_offset;
   logic [7:0]  rsp_byte_count;
   logic [15:0] rsp_load_address;
   logic [7:0]  rsp_record_type;
   logic [7:0]  rsp_check_byte;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   // parser model state
   logic        in_record;
   logic        bad_form;
   logic [3:0]  high_digit;
   logic        half_byte;
   logic [8:0]  bytes_taken;
   logic [7:0]  byte_sum;
   logic [7:0]  hdr_length;
   logic [15:0] hdr_address;
   logic [7:0]  hdr_type;
   logic [7:0]  held_byte;

   result_type   parsed_due[$];
   stim_row_type directed[$];
   int          fails = 0;
   int          cycles = 0;
   int          items_sent = 0;
   int          send_idle = 0;
   int          stall_pct = 0;
   int          hold_left = 0;

   hex_record_line_parser_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_value   (rsp_data_value),
      .rsp_data_offset  (rsp_data_offset),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_load_address (rsp_load_address),
      .rsp_record_type  (rsp_record_type),
      .rsp_check_byte   (rsp_check_byte),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic bit is_blank(input logic [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
   endfunction

   function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] d);
      d = 4'h0;
      if (c >= "0" && c <= "9") d = 4'(c - "0");
      else if (c >= "A" && c <= "F") d = 4'(c - "A" + 10);
      else if (c >= "a" && c <= "f") d = 4'(c - "a" + 10);
      else return 1'b0;
      return 1'b1;
   endfunction

   function automatic void clear_record();
      in_record   = 1'b0;
      bad_form    = 1'b0;
      high_digit  = 4'h0;
      half_byte   = 1'b0;
      bytes_taken = '0;
      byte_sum    = 8'h00;
      hdr_length  = 8'h00;
      hdr_address = 16'h0000;
      hdr_type    = 8'h00;
      held_byte   = 8'h00;
   endfunction

   // Advance the parser by one character or end marker; return 1 with the item it gives.
   function automatic bit parse_char(input logic [7:0] ch, input logic eol,
                                     output result_type res);
      logic [3:0] d;
      logic [7:0] b;
      bit         got;
      res = '0;
      res.byte_count   = hdr_length;
      res.load_address = hdr_address;
      res.record_type  = hdr_type;
      if (eol) begin
         res.kind        = KindSummary;
         res.last        = 1'b1;
         res.check_byte  = (bytes_taken >= DataStart) ? held_byte : 8'h00;
         if (bad_form || !in_record || bytes_taken < DataStart || half_byte)
            res.status = STATUS_BAD_FORM;
         else if (int'(bytes_taken) - DataStart != int'(hdr_length))
            res.status = STATUS_LENGTH;
         else if (byte_sum != 8'h00)
            res.status = STATUS_CHECKSUM;
         else
            res.status = STATUS_OK;
         clear_record();
         return 1'b1;
      end
      if (is_blank(ch)) return 1'b0;
      if (ch == ChColon) begin
         if (!in_record) in_record = 1'b1;
         else bad_form = 1'b1;
         return 1'b0;
      end
      if (!hex_digit(ch, d) || !in_record) begin
         bad_form = 1'b1;
         return 1'b0;
      end
      if (!half_byte) begin
         high_digit = d;
         half_byte  = 1'b1;
         return 1'b0;
      end
      half_byte = 1'b0;
      b = {high_digit, d};
      got = 1'b0;
      byte_sum = byte_sum + b;
      case (bytes_taken)
         9'd0: hdr_length = b;
         9'd1: hdr_address = {b, 8'h00};
         9'd2: hdr_address[7:0] = b;
         9'd3: hdr_type = b;
         default: begin
            // data goes out one byte late, so the checksum byte never does
            if (bytes_taken >= DataStart && int'(bytes_taken) - DataStart <= 255) begin
               res.kind        = KindData;
               res.data_value  = held_byte;
               res.data_offset = 8'(bytes_taken - DataStart);
               res.byte_count  = hdr_length;
               res.load_address = hdr_address;
               res.record_type = hdr_type;
               res.status      = STATUS_OK;
               got = 1'b1;
            end
            held_byte = b;
         end
      endcase
      if (bytes_taken != SeenMax) bytes_taken = bytes_taken + 9'd1;
      return got;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (parsed_due.size() == 0) begin
            $error("unexpected item: kind %0d offset %0d", rsp_kind, rsp_data_offset);
            fails++;
         end else begin
            w = parsed_due.pop_front();
            check_field("kind", w.kind, rsp_kind);
            check_field("data_value", w.data_value, rsp_data_value);
            check_field("data_offset", w.data_offset, rsp_data_offset);
            check_field("byte_count", w.byte_count, rsp_byte_count);
            check_field("load_address", w.load_address, rsp_load_address);
            check_field("record_type", w.record_type, rsp_record_type);
            check_field("check_byte", w.check_byte, rsp_check_byte);
            check_field("status", w.status, rsp_status);
            check_field("last", w.last, rsp_last);
         end
      end
   end

   task automatic send_item(input logic [7:0] ch, input logic eol, input bit typed = 1'b0,
                            input result_type want = '0);
      result_type r;
      if ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= ch;
      req_line_end  <= eol;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (parse_char(ch, eol, r)) parsed_due.push_back(typed ? want : r);
      items_sent++;
   endtask

   // hold the sender until every expected item is back
   task automatic drain();
      req_valid <= 1'b0;
      while (parsed_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_chars(input string s);
      stim_row_type row;
      for (int i = 0; i < s.len(); i++) begin
         row = '{ch: s[i], eol: 1'b0, typed: 1'b0, want: '0};
         directed.push_back(row);
      end
   endtask

   task automatic add_end(input logic [7:0] ch, input logic [7:0] cnt, input logic [15:0] addr,
                          input logic [7:0] typ, input logic [7:0] chk, input status_type st);
      stim_row_type row;
      row = '{ch: ch, eol: 1'b1, typed: 1'b1, want: '0};
      row.want.kind         = KindSummary;
      row.want.byte_count   = cnt;
      row.want.load_address = addr;
      row.want.record_type  = typ;
      row.want.check_byte   = chk;
      row.want.status       = st;
      row.want.last         = 1'b1;
      directed.push_back(row);
   endtask

   function automatic logic [7:0] digit_char(input logic [3:0] n);
      if (n < 10) return 8'("0" + n);
      return $urandom_range(0, 1) ? 8'("A" + n - 10) : 8'("a" + n - 10);
   endfunction

   function automatic logic [7:0] foreign_char();
      logic [7:0] c;
      logic [3:0] d;
      do c = 8'($urandom_range(0, 255));
      while (is_blank(c) || c == ChColon || hex_digit(c, d));
      return c;
   endfunction

   // One record line, mostly well formed with random content; some broken or pure noise.
   task automatic send_record(input bit huge);
      logic [7:0] bytes[$];
      logic [7:0] line[$];
      logic [7:0] sum;
      int         n;
      int         r;
      int         k;
      if (!huge && $urandom_range(0, 99) < 5) begin
         n = $urandom_range(1, 8);
         repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1);
         return;
      end
      r = $urandom_range(0, 99);
      if (huge) n = 515;
      else if (r < 70) n = $urandom_range(0, 16);
      else if (r < 95) n = $urandom_range(17, 40);
      else n = $urandom_range(0, 255);
      bytes.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : 8'(n));
      bytes.push_back(8'($urandom_range(0, 255)));
      bytes.push_back(8'($urandom_range(0, 255)));
      bytes.push_back($urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 5)));
      repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
      sum = 8'h00;
      foreach (bytes[i]) sum += bytes[i];
      sum = -sum;
      if ($urandom_range(0, 9) == 0) sum ^= 8'($urandom_range(1, 255));
      bytes.push_back(sum);

      line.push_back(ChColon);
      foreach (bytes[i]) begin
         line.push_back(digit_char(bytes[i][7:4]));
         line.push_back(digit_char(bytes[i][3:0]));
         if ($urandom_range(0, 99) < 8) begin
            k = $urandom_range(0, 5);
            line.push_back(k == 5 ? 8'd32 : 8'(9 + k));
         end
      end
      if (!huge && $urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 4))
            0: line.delete(0);
            1: line.insert($urandom_range(0, line.size()), ChColon);
            2: line.insert($urandom_range(0, line.size()), foreign_char());
            3: line.delete($urandom_range(1, line.size() - 1));
            default: begin
               k = $urandom_range(1, line.size());
               while (line.size() > k) void'(line.pop_back());
            end
         endcase
      end
      foreach (line[i]) send_item(line[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   initial begin
      int target;
      clear_record();

      // missing colon straight after reset; the character on an end marker is ignored
      add_end(ChColon, 8'h00, 16'h0000, 8'h00, 8'h00, STATUS_BAD_FORM);
      // good record, mixed case, blanks, extreme address
      add_chars(":01 FFFFaa\tfF58");
      add_end(8'hFF, 8'h01, 16'hFFFF, 8'hAA, 8'h58, STATUS_OK);
      // foreign character and a digit before the colon
      directed.push_back('{ch: 8'hFF, eol: 1'b0, typed: 1'b0, want: '0});
      add_chars("5:");
      add_end(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, STATUS_BAD_FORM);
      add_chars("::");
      add_end(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, STATUS_BAD_FORM);
      add_chars(":");
      directed.push_back('{ch: 8'h00, eol: 1'b0, typed: 1'b0, want: '0});
      add_end(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, STATUS_BAD_FORM);
      // short record, then an odd digit count
      add_chars(":00");
      add_end(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, STATUS_BAD_FORM);
      add_chars(":00000000000");
      add_end(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, STATUS_BAD_FORM);
      // length mismatch wins over a bad checksum
      add_chars(":0100000000");
      add_end(8'h00, 8'h01, 16'h0000, 8'h00, 8'h00, STATUS_LENGTH);
      add_chars(":0012340100");
      add_end(8'h00, 8'h00, 16'h1234, 8'h01, 8'h00, STATUS_CHECKSUM);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_item(directed[i].ch, directed[i].eol, directed[i].typed, directed[i].want);
      drain();

      items_sent = 0;
      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: begin send_idle = 0;  stall_pct = 0;  end
            1: begin send_idle = 54; stall_pct = 0;  end
            2: begin send_idle = 0;  stall_pct = 54; end
            3: begin send_idle = 14; stall_pct = 14; end
            default: begin send_idle = 0; stall_pct = 0; hold_left = 400; end
         endcase
         target = items_sent + (RandomItems - HugeItems) / (PhaseCount - 1);
         // overlong record under the long hold-off: fills the block and saturates the count
         if (p == PhaseCount - 1) send_record(1'b1);
         else while (items_sent < target) send_record(1'b0);
         drain();
      end

      if (fails == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
